// ----- rtl/core/upd_pkg.sv -----
// ----------------------------------------------------------------------------
// upd_pkg: shared types and helpers of the url query pair decoder
// result record, result batch, character codes and byte classification
// ----------------------------------------------------------------------------
package upd_pkg;

  // result kinds
  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_PAIR  = 2'd2;

  // escape phases
  localparam logic [1:0] ESC_NONE  = 2'd0;
  localparam logic [1:0] ESC_PCT   = 2'd1;
  localparam logic [1:0] ESC_DIGIT = 2'd2;

  // characters
  localparam logic [7:0] CHR_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CHR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHR_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CHR_AMP   = 8'h26;  // '&'
  localparam logic [7:0] CHR_QUEST = 8'h3F;  // '?'
  localparam logic [7:0] CHR_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CHR_0     = 8'd48;
  localparam logic [7:0] CHR_9     = 8'd57;
  localparam logic [7:0] CHR_A     = 8'd65;
  localparam logic [7:0] CHR_F     = 8'd70;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;

  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } res_t;

  // up to three results made by one request, in order from slot 0
  typedef struct packed {
    logic [1:0]             cnt;
    res_t [MAX_RES-1:0]     slot;
  } batch_t;

  // outcome of a byte seen with no escape pending
  typedef struct packed {
    logic emit;
    res_t res;
    logic value_nxt;
    logic esc_start;
  } plain_t;

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CHR_0 && c <= CHR_9) begin
      d = c - CHR_0;
    end else if (c >= CHR_A && c <= CHR_F) begin
      d = c - HEX_ALPHA_OFS;
    end
    return d[3:0];
  endfunction

  function automatic plain_t plain_byte(input logic [7:0] b, input logic last,
                                        input logic in_value);
    plain_t     p;
    logic [1:0] dk;
    dk          = in_value ? KIND_VALUE : KIND_KEY;
    p.emit      = 1'b0;
    p.res.kind  = dk;
    p.res.data  = b;
    p.res.last  = 1'b0;
    p.value_nxt = in_value;
    p.esc_start = 1'b0;
    case (b)
      CHR_EQ: begin
        p.value_nxt = 1'b1;
      end
      CHR_AMP: begin
        p.emit      = 1'b1;
        p.res.kind  = KIND_PAIR;
        p.res.data  = 8'd0;
        p.value_nxt = 1'b0;
      end
      CHR_PCT: begin
        if (last) begin
          p.emit = 1'b1;
        end else begin
          p.esc_start = 1'b1;
        end
      end
      CHR_PLUS: begin
        p.emit     = 1'b1;
        p.res.data = CHR_SPACE;
      end
      default: begin
        p.emit = 1'b1;
      end
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/core/url_query_pair_decoder_top.sv -----
// ----------------------------------------------------------------------------
// url_query_pair_decoder_top: url query string key/value byte decoder
// percent-decodes a url byte stream into tagged key, value and pair marks
// ----------------------------------------------------------------------------
// a request's results pass through the input register and then the result register
// throughput: one byte per cycle while each byte makes at most one result and out_stall is low
// after a byte with two or three results the next request making results
//   waits while the result register drains
// reset (rst_n low, synchronous): empty pipeline, key mode, no escape,
//   skip_to_question register back to 1
// ----------------------------------------------------------------------------
module url_query_pair_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_last_result
);

  // skip_to_question register, sampled at the first byte of each string
  logic cfg_skip_r;

  // input register
  logic       req_valid_r, req_valid_nxt;
  logic [7:0] req_byte_r;
  logic       req_last_r;

  logic            accept;
  logic            consume;
  logic            can_load;
  upd_pkg::batch_t batch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_skip_r <= 1'b1;
    end else if (cfg_wr_en) begin
      cfg_skip_r <= cfg_wr_data;
    end
  end

  // the held request leaves once its whole batch fits the result register;
  // a byte that makes no result leaves at once
  assign consume  = req_valid_r && (batch.cnt == 2'd0 || can_load);
  assign in_stall = req_valid_r && !consume;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    req_valid_nxt = req_valid_r;
    if (accept) begin
      req_valid_nxt = 1'b1;
    end else if (consume) begin
      req_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      req_byte_r <= in_byte;
      req_last_r <= in_last_byte;
    end
  end

  // per-byte decode and parse state
  upd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_skip  (cfg_skip_r),
    .req_valid (req_valid_r),
    .req_byte  (req_byte_r),
    .req_last  (req_last_r),
    .consume   (consume),
    .batch     (batch)
  );

  // result register, one result per cycle out while out_stall is low
  upd_out_buf u_out_buf (
    .clk             (clk),
    .rst_n           (rst_n),
    .batch           (batch),
    .can_load        (can_load),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_last_result (out_last_result)
  );

  // the input side only stalls behind a request already held
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> req_valid_r) else $error("stall with empty input register");

  // a request that made results is only consumed into a free result register
  a_consume_room: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && batch.cnt != 2'd0) |-> can_load)
    else $error("request consumed without room for its results");

endmodule

// ----- rtl/core/upd_parser.sv -----
// ----------------------------------------------------------------------------
// upd_parser: parse state and per-byte decode
// turns the registered request into a batch of up to three results
// ----------------------------------------------------------------------------
module upd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_skip,
  input  logic                req_valid,
  input  logic [7:0]          req_byte,
  input  logic                req_last,
  input  logic                consume,
  output upd_pkg::batch_t     batch
);

  logic       at_start_r,  at_start_nxt;
  logic       skipping_r,  skipping_nxt;
  logic       in_value_r,  in_value_nxt;
  logic [1:0] esc_r,       esc_nxt;
  logic [7:0] held_r,      held_nxt;

  logic             skip_eff;
  logic             val_cur;
  logic [1:0]       ptr;
  upd_pkg::plain_t  pb;
  upd_pkg::res_t    rr;
  upd_pkg::batch_t  bt;

  always_comb begin
    skip_eff     = at_start_r ? cfg_skip : skipping_r;
    skipping_nxt = skip_eff;
    in_value_nxt = in_value_r;
    esc_nxt      = esc_r;
    held_nxt     = held_r;
    at_start_nxt = 1'b0;
    val_cur      = in_value_r;
    bt           = '0;
    ptr          = 2'd0;
    pb           = upd_pkg::plain_byte(req_byte, req_last, in_value_r);
    rr           = '0;

    if (skip_eff) begin
      if (req_byte == upd_pkg::CHR_QUEST) begin
        skipping_nxt = 1'b0;
      end
    end else if (esc_r == upd_pkg::ESC_PCT) begin
      if (req_last) begin
        // short escape: literal '%' then the last byte as plain data
        rr.kind       = in_value_r ? upd_pkg::KIND_VALUE : upd_pkg::KIND_KEY;
        rr.data       = upd_pkg::CHR_PCT;
        rr.last       = 1'b0;
        bt.slot[ptr]  = rr;
        ptr           = ptr + 2'd1;
        esc_nxt       = upd_pkg::ESC_NONE;
        if (pb.emit) begin
          bt.slot[ptr] = pb.res;
          ptr          = ptr + 2'd1;
        end
        in_value_nxt = pb.value_nxt;
      end else begin
        held_nxt = req_byte;
        esc_nxt  = upd_pkg::ESC_DIGIT;
      end
    end else if (esc_r == upd_pkg::ESC_DIGIT) begin
      rr.kind      = val_cur ? upd_pkg::KIND_VALUE : upd_pkg::KIND_KEY;
      rr.data      = {upd_pkg::hex_val(held_r), upd_pkg::hex_val(req_byte)};
      rr.last      = 1'b0;
      bt.slot[ptr] = rr;
      ptr          = ptr + 2'd1;
      esc_nxt      = upd_pkg::ESC_NONE;
      held_nxt     = 8'd0;
    end else begin
      esc_nxt = pb.esc_start ? upd_pkg::ESC_PCT : upd_pkg::ESC_NONE;
      if (pb.emit) begin
        bt.slot[ptr] = pb.res;
        ptr          = ptr + 2'd1;
      end
      in_value_nxt = pb.value_nxt;
    end

    if (req_last) begin
      // end of string closes the pair and re-arms
      rr.kind      = upd_pkg::KIND_PAIR;
      rr.data      = 8'd0;
      rr.last      = 1'b1;
      bt.slot[ptr] = rr;
      ptr          = ptr + 2'd1;
      skipping_nxt = cfg_skip;
      in_value_nxt = 1'b0;
      esc_nxt      = upd_pkg::ESC_NONE;
      held_nxt     = 8'd0;
      at_start_nxt = 1'b1;
    end
    bt.cnt = req_valid ? ptr : 2'd0;
    batch  = bt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r <= 1'b1;
      skipping_r <= 1'b1;
      in_value_r <= 1'b0;
      esc_r      <= upd_pkg::ESC_NONE;
      held_r     <= 8'd0;
    end else if (consume) begin
      at_start_r <= at_start_nxt;
      skipping_r <= skipping_nxt;
      in_value_r <= in_value_nxt;
      esc_r      <= esc_nxt;
      held_r     <= held_nxt;
    end
  end

  // escape phase never takes the unused code
  a_esc_code: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r != 2'd3) else $error("escape phase out of range");

  // a last byte always ends with the closing pair mark
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid && req_last) |-> (batch.cnt != 2'd0 &&
      batch.slot[batch.cnt - 2'd1].last && 
      batch.slot[batch.cnt - 2'd1].kind == upd_pkg::KIND_PAIR))
    else $error("last byte did not close the pair");

endmodule

// ----- rtl/core/upd_out_buf.sv -----
// ----------------------------------------------------------------------------
// upd_out_buf: result register
// holds a batch of results and, while out_stall is low, hands them out one per cycle
// ----------------------------------------------------------------------------
module upd_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  upd_pkg::batch_t     batch,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_byte,
  output logic                out_last_result
);

  upd_pkg::res_t [upd_pkg::MAX_RES-1:0] slot_r, slot_nxt;
  logic [1:0]                           cnt_r,  cnt_nxt;
  logic                                 pop;
  logic                                 load;

  assign pop      = (cnt_r != 2'd0) && !out_stall;
  assign can_load = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);
  assign load     = (batch.cnt != 2'd0) && can_load;

  always_comb begin
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      slot_nxt = batch.slot;
      cnt_nxt  = batch.cnt;
    end else if (pop) begin
      slot_nxt[0] = slot_r[1];
      slot_nxt[1] = slot_r[2];
      cnt_nxt     = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign out_valid       = cnt_r != 2'd0;
  assign out_kind        = slot_r[0].kind;
  assign out_byte        = slot_r[0].data;
  assign out_last_result = slot_r[0].last;

  // a new batch only lands on an empty or draining register
  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (cnt_r == 2'd0 || (cnt_r == 2'd1 && pop)))
    else $error("batch loaded over pending results");

  // a stalled result is still there next cycle
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_byte) &&
      $stable(out_kind) && $stable(out_last_result)))
    else $error("stalled result changed");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for url_query_pair_decoder_top
// drives url byte strings through the request channel under random idle and
// stall, predicts every tagged key/value/pair result and checks them in order
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned   ITEMS_TOTAL = 430;
  localparam int unsigned   HOLD_CYC    = 120;  // long receiver hold-off
  localparam int unsigned   DRAIN_CYC   = 8;    // latency margin before idle actions
  localparam upd_pkg::res_t NO_RES      = '0;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_op_t;

  // one row of the directed table: a request byte or a register write
  typedef struct {
    row_op_t       op;
    logic [7:0]    b;
    logic          last;
    bit            typed;
    int unsigned   n;
    upd_pkg::res_t want [3];
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic       cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last_result;

  // predictor state
  logic       skip_reg;
  logic       skipping;
  logic       value_mode;
  logic [1:0] esc_phase;
  logic [7:0] held_digit;
  logic       at_start;

  upd_pkg::res_t step_res [$];     // results of the request just decoded
  upd_pkg::res_t pending_res [$];  // results still owed by the block
  logic [7:0]    str_q [$];        // url string being built
  dir_row_t      dir_tab [$];
  upd_pkg::res_t want;
  int unsigned   err_cnt = 0;
  int unsigned   items_sent = 0;
  int unsigned   burst_left = 0;
  bit            hold_req = 1'b0;

  always #2 clk = ~clk;

  url_query_pair_decoder_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_last_result (out_last_result)
  );

  task automatic note_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 40) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return c[3:0];
    end
    if (c >= "A" && c <= "F") begin
      return c[3:0] + 4'd9;
    end
    return 4'd0;
  endfunction

  function automatic upd_pkg::res_t rs(input logic [1:0] k, input logic [7:0] d,
                                       input logic l);
    upd_pkg::res_t r;
    r.kind = k;
    r.data = d;
    r.last = l;
    return r;
  endfunction

  task automatic put_data(input logic [7:0] d);
    step_res.push_back(rs(value_mode ? upd_pkg::KIND_VALUE : upd_pkg::KIND_KEY, d, 1'b0));
  endtask

  // byte with no escape pending
  task automatic decode_plain(input logic [7:0] b, input logic last);
    case (b)
      upd_pkg::CHR_EQ: begin
        value_mode = 1'b1;
      end
      upd_pkg::CHR_AMP: begin
        step_res.push_back(rs(upd_pkg::KIND_PAIR, 8'd0, 1'b0));
        value_mode = 1'b0;
      end
      upd_pkg::CHR_PCT: begin
        if (last) begin
          put_data(b);
        end else begin
          esc_phase = upd_pkg::ESC_PCT;
        end
      end
      upd_pkg::CHR_PLUS: begin
        put_data(upd_pkg::CHR_SPACE);
      end
      default: begin
        put_data(b);
      end
    endcase
  endtask

  task automatic rearm_string();
    skipping   = skip_reg;
    value_mode = 1'b0;
    esc_phase  = upd_pkg::ESC_NONE;
    held_digit = 8'd0;
    at_start   = 1'b1;
  endtask

  task automatic decode_step(input logic [7:0] b, input logic last);
    step_res.delete();
    if (at_start) begin
      skipping = skip_reg;
      at_start = 1'b0;
    end
    if (skipping) begin
      if (b == upd_pkg::CHR_QUEST) begin
        skipping = 1'b0;
      end
    end else if (esc_phase == upd_pkg::ESC_PCT) begin
      if (last) begin
        // short escape: literal '%', then the final byte as plain data
        put_data(upd_pkg::CHR_PCT);
        esc_phase = upd_pkg::ESC_NONE;
        decode_plain(b, 1'b1);
      end else begin
        held_digit = b;
        esc_phase  = upd_pkg::ESC_DIGIT;
      end
    end else if (esc_phase == upd_pkg::ESC_DIGIT) begin
      put_data({hex_digit(held_digit), hex_digit(b)});
      esc_phase  = upd_pkg::ESC_NONE;
      held_digit = 8'd0;
    end else begin
      decode_plain(b, last);
    end
    if (last) begin
      step_res.push_back(rs(upd_pkg::KIND_PAIR, 8'd0, 1'b1));
      rearm_string();
    end
  endtask

  // ----------------------------------------------------------- request side

  // offer one byte and hold it until the block takes it
  task automatic offer_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    in_valid     <= 1'b1;
    in_byte      <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  task automatic idle_gap(input int unsigned n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // mostly back to back, sometimes short gaps, rarely long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 15);
    if (r < 9) begin
      return 0;
    end
    if (r < 14) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic send_predicted(input logic [7:0] b, input logic last);
    offer_byte(b, last);
    decode_step(b, last);
    foreach (step_res[i]) pending_res.push_back(step_res[i]);
    idle_gap(pick_gap());
  endtask

  // register write only once the block has drained
  task automatic write_skip(input logic v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    skip_reg = v;
  endtask

  // ------------------------------------------------------------ random strings

  function automatic logic [7:0] hex_char(input int unsigned d);
    return (d < 10) ? 8'(48 + d) : 8'(55 + d);
  endfunction

  task automatic push_char();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 8) begin
      case ($urandom_range(0, 2))
        0: str_q.push_back(8'($urandom_range(97, 122)));
        1: str_q.push_back(8'($urandom_range(65, 90)));
        default: str_q.push_back(8'($urandom_range(48, 57)));
      endcase
    end else if (r < 10) begin
      str_q.push_back(upd_pkg::CHR_PLUS);
    end else if (r < 14) begin
      // escape, mostly with valid uppercase hex digits
      str_q.push_back(upd_pkg::CHR_PCT);
      repeat (2) begin
        if ($urandom_range(0, 3) != 0) begin
          str_q.push_back(hex_char($urandom_range(0, 15)));
        end else begin
          str_q.push_back(8'($urandom_range(0, 255)));
        end
      end
    end else if (r < 17) begin
      str_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 3))
        0: str_q.push_back(upd_pkg::CHR_EQ);
        1: str_q.push_back(upd_pkg::CHR_AMP);
        2: str_q.push_back(upd_pkg::CHR_PCT);
        default: str_q.push_back(upd_pkg::CHR_QUEST);
      endcase
    end
  endtask

  task automatic fill_string();
    int unsigned npairs;
    logic [7:0]  c;
    str_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      // noise string
      repeat ($urandom_range(1, 6)) str_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (skip_reg && $urandom_range(0, 7) != 0) begin
      repeat ($urandom_range(0, 4)) begin
        do c = 8'($urandom_range(0, 255)); while (c == upd_pkg::CHR_QUEST);
        str_q.push_back(c);
      end
      str_q.push_back(upd_pkg::CHR_QUEST);
    end
    npairs = $urandom_range(1, 3);
    for (int unsigned p = 0; p < npairs; p++) begin
      repeat ($urandom_range(0, 3)) push_char();
      if ($urandom_range(0, 5) != 0) begin
        str_q.push_back(upd_pkg::CHR_EQ);
      end
      repeat ($urandom_range(0, 4)) push_char();
      if (p + 1 < npairs) begin
        str_q.push_back(upd_pkg::CHR_AMP);
      end
    end
    // broken tails: short escapes and a trailing separator
    case ($urandom_range(0, 9))
      0: str_q.push_back(upd_pkg::CHR_PCT);
      1: begin
        str_q.push_back(upd_pkg::CHR_PCT);
        str_q.push_back(8'($urandom_range(0, 255)));
      end
      2: str_q.push_back(upd_pkg::CHR_AMP);
      default: ;
    endcase
    if (str_q.size() == 0) begin
      str_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------- directed table

  function automatic dir_row_t dt(input logic [7:0] b, input logic l, input int unsigned n,
                                  input upd_pkg::res_t r0, input upd_pkg::res_t r1,
                                  input upd_pkg::res_t r2);
    dir_row_t row;
    row.op      = ROW_BYTE;
    row.b       = b;
    row.last    = l;
    row.typed   = 1'b1;
    row.n       = n;
    row.want[0] = r0;
    row.want[1] = r1;
    row.want[2] = r2;
    return row;
  endfunction

  function automatic dir_row_t dr(input logic [7:0] b, input logic l);
    dir_row_t row;
    row       = dt(b, l, 0, NO_RES, NO_RES, NO_RES);
    row.typed = 1'b0;
    return row;
  endfunction

  function automatic dir_row_t dc(input logic v);
    dir_row_t row;
    row    = dr({7'd0, v}, 1'b0);
    row.op = ROW_CFG;
    return row;
  endfunction

  task automatic build_dir_tab();
    // skip on after reset: bytes up to '?' vanish
    dir_tab.push_back(dt("x", 1'b0, 0, NO_RES, NO_RES, NO_RES));
    dir_tab.push_back(dt(upd_pkg::CHR_QUEST, 1'b0, 0, NO_RES, NO_RES, NO_RES));
    dir_tab.push_back(dt(8'h00, 1'b0, 1, rs(upd_pkg::KIND_KEY, 8'h00, 1'b0),
                         NO_RES, NO_RES));
    dir_tab.push_back(dt(upd_pkg::CHR_EQ, 1'b0, 0, NO_RES, NO_RES, NO_RES));
    dir_tab.push_back(dt(8'hFF, 1'b0, 1, rs(upd_pkg::KIND_VALUE, 8'hFF, 1'b0),
                         NO_RES, NO_RES));
    // repeated '=' in value mode is silent
    dir_tab.push_back(dt(upd_pkg::CHR_EQ, 1'b0, 0, NO_RES, NO_RES, NO_RES));
    dir_tab.push_back(dt(upd_pkg::CHR_PLUS, 1'b0, 1,
                         rs(upd_pkg::KIND_VALUE, upd_pkg::CHR_SPACE, 1'b0), NO_RES, NO_RES));
    // %3D decodes to '=' as plain data
    dir_tab.push_back(dt(upd_pkg::CHR_PCT, 1'b0, 0, NO_RES, NO_RES, NO_RES));
    dir_tab.push_back(dr("3", 1'b0));
    dir_tab.push_back(dt("D", 1'b0, 1, rs(upd_pkg::KIND_VALUE, upd_pkg::CHR_EQ, 1'b0),
                         NO_RES, NO_RES));
    dir_tab.push_back(dt(upd_pkg::CHR_AMP, 1'b0, 1, rs(upd_pkg::KIND_PAIR, 8'd0, 1'b0),
                         NO_RES, NO_RES));
    // a non-hex digit such as lowercase 'g' counts as zero
    dir_tab.push_back(dr(upd_pkg::CHR_PCT, 1'b0));
    dir_tab.push_back(dr("g", 1'b0));
    dir_tab.push_back(dr("F", 1'b0));
    // '&' as final byte closes twice
    dir_tab.push_back(dt(upd_pkg::CHR_AMP, 1'b1, 2, rs(upd_pkg::KIND_PAIR, 8'd0, 1'b0),
                         rs(upd_pkg::KIND_PAIR, 8'd0, 1'b1), NO_RES));
    // no '?' while skipping: one empty final pair
    dir_tab.push_back(dt("b", 1'b1, 1, rs(upd_pkg::KIND_PAIR, 8'd0, 1'b1), NO_RES, NO_RES));
    dir_tab.push_back(dc(1'b0));
    // '%' as the final byte passes through
    dir_tab.push_back(dt(upd_pkg::CHR_PCT, 1'b1, 2,
                         rs(upd_pkg::KIND_KEY, upd_pkg::CHR_PCT, 1'b0),
                         rs(upd_pkg::KIND_PAIR, 8'd0, 1'b1), NO_RES));
    // one byte after '%' then end: literal '%' plus the byte as plain
    dir_tab.push_back(dr(upd_pkg::CHR_PCT, 1'b0));
    dir_tab.push_back(dt(upd_pkg::CHR_AMP, 1'b1, 3,
                         rs(upd_pkg::KIND_KEY, upd_pkg::CHR_PCT, 1'b0),
                         rs(upd_pkg::KIND_PAIR, 8'd0, 1'b0),
                         rs(upd_pkg::KIND_PAIR, 8'd0, 1'b1)));
    // register write mid-string only counts from the next string
    dir_tab.push_back(dr("k", 1'b0));
    dir_tab.push_back(dr(upd_pkg::CHR_EQ, 1'b0));
    dir_tab.push_back(dc(1'b1));
    dir_tab.push_back(dr(upd_pkg::CHR_PCT, 1'b0));
    dir_tab.push_back(dr("2", 1'b0));
    dir_tab.push_back(dr("5", 1'b0));
    dir_tab.push_back(dr(upd_pkg::CHR_PCT, 1'b1));
    dir_tab.push_back(dr(upd_pkg::CHR_QUEST, 1'b0));
    dir_tab.push_back(dt("z", 1'b1, 2, rs(upd_pkg::KIND_KEY, "z", 1'b0),
                         rs(upd_pkg::KIND_PAIR, 8'd0, 1'b1), NO_RES));
  endtask

  // ------------------------------------------------------------- result side

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int unsigned stall_left;
    int unsigned quiet_left;
    int unsigned r;
    logic        nxt;
    stall_left = 0;
    quiet_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYC;
        quiet_left = 0;
      end
      if (stall_left == 0 && quiet_left == 0) begin
        r = $urandom_range(0, 15);
        if (r < 9) begin
          quiet_left = $urandom_range(1, 6);
        end else if (r < 13) begin
          stall_left = $urandom_range(1, 3);
        end else if (r < 14) begin
          stall_left = $urandom_range(8, 30);
        end else begin
          quiet_left = $urandom_range(20, 60);
        end
      end
      if (stall_left > 0) begin
        nxt = 1'b1;
        stall_left--;
      end else begin
        nxt = 1'b0;
        quiet_left--;
      end
      out_stall <= nxt;
    end
  end

  // in-order check of every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_res.size() == 0) begin
        note_mismatch($sformatf("result kind %0d byte %02h with nothing pending",
                                out_kind, out_byte));
      end else begin
        want = pending_res.pop_front();
        if (out_kind !== want.kind) begin
          note_mismatch($sformatf("kind got %0d want %0d", out_kind, want.kind));
        end
        if (out_byte !== want.data) begin
          note_mismatch($sformatf("byte got %02h want %02h", out_byte, want.data));
        end
        if (out_last_result !== want.last) begin
          note_mismatch($sformatf("last got %b want %b", out_last_result, want.last));
        end
      end
    end
  end

  // generous limit, covers a hang anywhere
  initial begin
    #2000000;
    $display("FAIL url_query_pair_decoder_top");
    $finish;
  end

  // ---------------------------------------------------------------- main flow
  initial begin
    int unsigned next_cfg_at;
    int unsigned cfg_cnt;
    bit          pressure_done;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 1'b0;
    in_valid     = 1'b0;
    in_byte      = 8'd0;
    in_last_byte = 1'b0;
    skip_reg     = 1'b1;
    rearm_string();
    build_dir_tab();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == ROW_CFG) begin
        write_skip(dir_tab[i].b[0]);
      end else if (dir_tab[i].typed) begin
        offer_byte(dir_tab[i].b, dir_tab[i].last);
        decode_step(dir_tab[i].b, dir_tab[i].last);
        for (int unsigned k = 0; k < dir_tab[i].n; k++) begin
          pending_res.push_back(dir_tab[i].want[k]);
        end
        idle_gap(pick_gap());
      end else begin
        send_predicted(dir_tab[i].b, dir_tab[i].last);
      end
    end

    // random strings, register rewritten between phases, mostly flipped
    next_cfg_at   = items_sent + $urandom_range(40, 90);
    cfg_cnt       = 0;
    pressure_done = 1'b0;
    while (items_sent < ITEMS_TOTAL) begin
      if (items_sent >= next_cfg_at) begin
        cfg_cnt++;
        write_skip((cfg_cnt % 3 == 0) ? 1'($urandom_range(0, 1)) : ~skip_reg);
        next_cfg_at = items_sent + $urandom_range(40, 90);
      end
      if (!pressure_done && items_sent >= 200) begin
        // receiver holds off while requests keep coming back to back
        pressure_done = 1'b1;
        hold_req      = 1'b1;
        burst_left    = 40;
      end
      fill_string();
      foreach (str_q[i]) begin
        send_predicted(str_q[i], i == str_q.size() - 1);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS url_query_pair_decoder_top");
    end else begin
      $display("FAIL url_query_pair_decoder_top");
    end
    $finish;
  end

endmodule
